[rtl/fhn_pkg.sv]
// fhn_pkg: shared types, defaults and datapath command codes for the
// fitzhugh-nagumo neuron update block; used by every rtl module here
`timescale 1ns / 1ps
`default_nettype none

package fhn_pkg;

    localparam int DEF_NEURON_COUNT = 1024;
    localparam int DEF_FRAC_BITS    = 24;

    localparam int IDX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int STEPS_W = 11;
    localparam int SCALE_W = 25;
    localparam int CFG_IDX_W = 3;

    // register reset values, q8.24
    localparam logic signed [DATA_W-1:0] RST_COEFF_A   = 32'sd11744051;
    localparam logic signed [DATA_W-1:0] RST_COEFF_B   = 32'sd13421773;
    localparam logic signed [DATA_W-1:0] RST_COEFF_PHI = 32'sd1342177;
    localparam logic [STEPS_W-1:0]       RST_STEPS     = 11'd1;
    localparam logic [SCALE_W-1:0]       RST_SCALE     = 25'd16777216;
    localparam logic signed [DATA_W-1:0] RST_START_X   = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_START_W   = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_A   = 3'd0,
        REG_COEFF_B   = 3'd1,
        REG_COEFF_PHI = 3'd2,
        REG_STEPS     = 3'd3,
        REG_SCALE     = 3'd4,
        REG_START_X   = 3'd5,
        REG_START_W   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]         neuron_index;
        logic signed [DATA_W-1:0] drive_current;
        logic                     restart;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]         neuron_id_out;
        logic                     fired;
        logic signed [DATA_W-1:0] membrane_out;
        logic signed [DATA_W-1:0] recovery_out;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_READ,
        OP_LOAD,
        OP_MUL_XX,
        OP_MUL_TX,
        OP_MUL_T3,
        OP_MUL_BW,
        OP_MUL_PHIT,
        OP_MUL_DXS,
        OP_MUL_DWS,
        OP_CAP_T,
        OP_SUB_XP,
        OP_SUB_TW,
        OP_ADD_TI,
        OP_ADD_XA,
        OP_SUB_TP,
        OP_CAP_DW,
        OP_ADD_XP,
        OP_ADD_WP,
        OP_FIRE,
        OP_WRITE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic               restart;
        logic               out_busy;
        logic [STEPS_W-1:0] step_count;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/fhn_datapath.sv]
// fhn_datapath: config registers, neuron state memories, shared multiplier,
// saturating adders and output register; depends on fhn_pkg
`timescale 1ns / 1ps
`default_nettype none

module fhn_datapath
    import fhn_pkg::*;
#(
    parameter int NEURON_COUNT = DEF_NEURON_COUNT,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire t_in_word             i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 i_stall,
    output t_dp_stat                  o_stat,
    output logic                      o_valid,
    output t_out_word                 o_out
);

    localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam logic signed [DATA_W-1:0] ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] THIRD = 32'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic signed [63:0] MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] MIN64 = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? MIN32 : MAX32;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > MAX64) begin
            r = MAX32;
        end else if (v < MIN64) begin
            r = MIN32;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [DATA_W-1:0] r_coeff_a, r_coeff_b, r_coeff_phi, r_start_x, r_start_w;
    logic [STEPS_W-1:0]       r_steps;
    logic [SCALE_W-1:0]       r_scale;

    // neuron state
    logic signed [DATA_W-1:0] mem_x [NEURON_COUNT];
    logic signed [DATA_W-1:0] mem_w [NEURON_COUNT];
    logic signed [DATA_W-1:0] r_mx, r_mw;

    // working registers
    logic [IDX_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_drive;
    logic                     r_restart;
    logic signed [DATA_W-1:0] r_x, r_w, r_t, r_dx, r_dw;
    logic signed [63:0]       r_prod;
    logic                     r_fired;
    logic                     r_out_valid;
    t_out_word                r_out;

    logic                     w_inside;
    logic [AW-1:0]            w_addr;
    logic signed [63:0]       w_shift;
    logic signed [DATA_W-1:0] w_fx;
    logic signed [DATA_W-1:0] w_op_a, w_op_b, w_scale;
    logic                     w_mul;

    assign w_inside = (32'(r_idx) < NEURON_COUNT);
    assign w_addr   = AW'(r_idx);
    assign w_scale  = 32'($signed({1'b0, r_scale}));
    // floor shift of the product, then clamp to 32 bits
    assign w_shift  = r_prod >>> FRAC_BITS;
    assign w_fx     = sat64(w_shift);

    always_comb begin
        w_mul  = 1'b1;
        w_op_a = r_x;
        w_op_b = r_x;
        unique case (i_cmd.op)
            OP_MUL_XX:   begin w_op_a = r_x;         w_op_b = r_x;     end
            OP_MUL_TX:   begin w_op_a = r_t;         w_op_b = r_x;     end
            OP_MUL_T3:   begin w_op_a = r_t;         w_op_b = THIRD;   end
            OP_MUL_BW:   begin w_op_a = r_coeff_b;   w_op_b = r_w;     end
            OP_MUL_PHIT: begin w_op_a = r_coeff_phi; w_op_b = r_t;     end
            OP_MUL_DXS:  begin w_op_a = r_dx;        w_op_b = w_scale; end
            OP_MUL_DWS:  begin w_op_a = r_dw;        w_op_b = w_scale; end
            default:     w_mul = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a   <= RST_COEFF_A;
            r_coeff_b   <= RST_COEFF_B;
            r_coeff_phi <= RST_COEFF_PHI;
            r_steps     <= RST_STEPS;
            r_scale     <= RST_SCALE;
            r_start_x   <= RST_START_X;
            r_start_w   <= RST_START_W;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_COEFF_A:   r_coeff_a   <= i_cfg_data;
                REG_COEFF_B:   r_coeff_b   <= i_cfg_data;
                REG_COEFF_PHI: r_coeff_phi <= i_cfg_data;
                REG_STEPS:     r_steps     <= i_cfg_data[STEPS_W-1:0];
                REG_SCALE:     r_scale     <= i_cfg_data[SCALE_W-1:0];
                REG_START_X:   r_start_x   <= i_cfg_data;
                REG_START_W:   r_start_w   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_READ) begin
            r_mx <= mem_x[w_addr];
            r_mw <= mem_w[w_addr];
        end
        if (i_cmd.op == OP_WRITE && w_inside) begin
            mem_x[w_addr] <= r_x;
            mem_w[w_addr] <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= 64'(w_op_a) * 64'(w_op_b);
        end
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_idx     <= i_in.neuron_index;
                r_drive   <= i_in.drive_current;
                r_restart <= i_in.restart;
            end
            OP_LOAD: begin
                r_fired <= 1'b0;
                if (r_restart) begin
                    r_x <= r_start_x;
                    r_w <= r_start_w;
                end else begin
                    r_x <= w_inside ? r_mx : '0;
                    r_w <= w_inside ? r_mw : '0;
                end
            end
            OP_CAP_T:  r_t  <= w_fx;
            OP_SUB_XP: r_t  <= sat33(33'(r_x) - 33'(w_fx));
            OP_SUB_TW: r_t  <= sat33(33'(r_t) - 33'(r_w));
            OP_ADD_TI: r_dx <= sat33(33'(r_t) + 33'(r_drive));
            OP_ADD_XA: r_t  <= sat33(33'(r_x) + 33'(r_coeff_a));
            OP_SUB_TP: r_t  <= sat33(33'(r_t) - 33'(w_fx));
            OP_CAP_DW: r_dw <= w_fx;
            OP_ADD_XP: r_x  <= sat33(33'(r_x) + 33'(w_fx));
            OP_ADD_WP: r_w  <= sat33(33'(r_w) + 33'(w_fx));
            OP_FIRE:   r_fired <= (r_w > r_t) && (r_x > ONE);
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_WRITE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) begin
            r_out.neuron_id_out <= r_idx;
            r_out.fired         <= r_fired;
            r_out.membrane_out  <= r_x;
            r_out.recovery_out  <= r_w;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;
    assign o_stat  = '{restart: r_restart, out_busy: r_out_valid && i_stall,
                       step_count: r_steps};

endmodule

`default_nettype wire

[rtl/fhn_ctrl.sv]
// fhn_ctrl: sequencer that walks the euler step and spike test micro-ops
// and drives the datapath command; depends on fhn_pkg
`timescale 1ns / 1ps
`default_nettype none

module fhn_ctrl
    import fhn_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_STEP,
        S_TEST,
        S_FINISH
    } t_state;

    localparam logic [4:0] STEP_LAST = 5'd16;
    localparam logic [4:0] TEST_LAST = 5'd6;

    // one euler step; each multiply's product is used by a later op before the next multiply
    function automatic t_dp_op step_op(input logic [4:0] pc);
        t_dp_op op;
        unique case (pc)
            5'd0:    op = OP_MUL_XX;
            5'd1:    op = OP_CAP_T;
            5'd2:    op = OP_MUL_TX;
            5'd3:    op = OP_CAP_T;
            5'd4:    op = OP_MUL_T3;
            5'd5:    op = OP_SUB_XP;
            5'd6:    op = OP_SUB_TW;
            5'd7:    op = OP_ADD_TI;
            5'd8:    op = OP_MUL_BW;
            5'd9:    op = OP_ADD_XA;
            5'd10:   op = OP_SUB_TP;
            5'd11:   op = OP_MUL_PHIT;
            5'd12:   op = OP_CAP_DW;
            5'd13:   op = OP_MUL_DXS;
            5'd14:   op = OP_ADD_XP;
            5'd15:   op = OP_MUL_DWS;
            5'd16:   op = OP_ADD_WP;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    // spike test reuses the x - x^3/3 head of the step
    function automatic t_dp_op test_op(input logic [4:0] pc);
        t_dp_op op;
        if (pc < TEST_LAST) begin
            op = step_op(pc);
        end else begin
            op = OP_FIRE;
        end
        return op;
    endfunction

    t_state             r_state;
    logic [4:0]         r_pc;
    logic [STEPS_W-1:0] r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_pc   <= '0;
                    r_left <= i_stat.step_count;
                    if (i_stat.restart) begin
                        r_state <= S_FINISH;
                    end else if (i_stat.step_count == '0) begin
                        r_state <= S_TEST;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_pc == STEP_LAST) begin
                        r_pc   <= '0;
                        r_left <= r_left - 1'b1;
                        if (r_left == STEPS_W'(1)) begin
                            r_state <= S_TEST;
                        end
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_TEST: begin
                    if (r_pc == TEST_LAST) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:   o_cmd.op = i_valid ? OP_LATCH : OP_NOP;
            S_READ:   o_cmd.op = OP_READ;
            S_LOAD:   o_cmd.op = OP_LOAD;
            S_STEP:   o_cmd.op = step_op(r_pc);
            S_TEST:   o_cmd.op = test_op(r_pc);
            S_FINISH: o_cmd.op = i_stat.out_busy ? OP_NOP : OP_WRITE;
            default:  o_cmd.op = OP_NOP;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/fitzhugh_nagumo_neuron_update.sv]
// fitzhugh-nagumo neuron update: one word in, one word out; the input side stalls while a
// word is worked on, so a new word is taken only after the result is in the output register
// (step_count = 0: spike test only; restart: start values, no euler step and no spike test)
// each euler step is a sequence of micro-ops on one 32x32 multiplier; a waiting result adds its stall
// the output register lets the next word be taken while a result waits
// synchronous active-low reset clears control and config; state memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module fitzhugh_nagumo_neuron_update
    import fhn_pkg::*;
#(
    parameter int NEURON_COUNT = DEF_NEURON_COUNT,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_word             i_in,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_word                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fhn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_busy  (o_stall),
        .o_cmd   (w_cmd)
    );

    fhn_datapath #(
        .NEURON_COUNT (NEURON_COUNT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stall    (i_stall),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[rtl/fhn_checker.sv]
// fhn_checker: port-level assertions for the neuron update block, bound to
// the top level; depends on fhn_pkg
`timescale 1ns / 1ps
`default_nettype none

module fhn_checker
    import fhn_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_word o_out
);

    localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

    // no word leaves right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // one word in flight: an accepted word makes the input side stall
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // a new result only appears while a word was being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a word in flight");

    // a spike needs the membrane above one
    a_fired_membrane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.fired) |-> (o_out.membrane_out > ONE))
        else $error("fired with membrane not above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled output word changed");

endmodule

bind fitzhugh_nagumo_neuron_update fhn_checker #(.FRAC_BITS(FRAC_BITS)) u_fhn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

`default_nettype wire
